@@ hw/rtl/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam int PEND_W = 7;
  localparam int CNT_W  = 3;
  localparam int ACC_W  = MAX_CODE_LEN + PEND_W;
  localparam int MAX_BYTES = ACC_W / 8;
  localparam int JOB_W  = MAX_BYTES * 8;
  localparam int TOT_W  = $clog2(ACC_W + 1);
  localparam int NB_W   = $clog2(MAX_BYTES + 1);

  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_LEN);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_entry_t;

  typedef struct packed {
    logic              valid;
    logic [NB_W-1:0]   nbytes;
    logic [JOB_W-1:0]  bits;
  } job_t;

endpackage

@@ hw/rtl/hcbp_table.sv @@
// Code table: synchronous memory of code word and length per symbol.
// Per-entry valid bits make unloaded entries read as length zero. Uses hcbp_pkg.
module hcbp_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic                      rd_en,
  input  logic [hcbp_pkg::SYM_W-1:0] sym,
  input  logic [hcbp_pkg::CODE_W-1:0] wr_code,
  input  logic [hcbp_pkg::LEN_W-1:0]  wr_len,
  output hcbp_pkg::tbl_entry_t       rd_entry
);
  import hcbp_pkg::*;

  tbl_entry_t              tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;
  tbl_entry_t              rd_data_r;
  logic                    rd_hit_r;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  tbl_entry_t              wr_data;

  always_comb begin
    in_range     = ({1'b0, sym} < SYM_LIMIT);
    idx          = sym[IDX_W-1:0];
    wr_data.code = wr_code;
    wr_data.len  = (wr_len > LEN_MAX) ? LEN_MAX : wr_len;
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      tbl_mem[idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en && in_range) begin
        valid_r[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= in_range && valid_r[idx];
      end
    end
  end

  always_comb begin
    rd_entry.code = rd_data_r.code;
    rd_entry.len  = rd_hit_r ? rd_data_r.len : '0;
  end

endmodule

@@ hw/rtl/hcbp_pack.sv @@
// Bit accumulator: merges pending bits with the looked-up code word and
// hands whole bytes, left aligned, to the emitter. Uses hcbp_pkg.
module hcbp_pack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  hcbp_pkg::func_t      in_func,
  input  hcbp_pkg::tbl_entry_t rd_entry,
  input  logic                 job_ready,
  output logic                 stage_ready,
  output hcbp_pkg::job_t       job
);
  import hcbp_pkg::*;

  logic              s1_valid_r;
  func_t             s1_func_r;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              is_enc, is_flush, advance;
  logic [LEN_W-1:0]  len_eff;
  logic [ACC_W-1:0]  mask, acc, aligned;
  logic [TOT_W-1:0]  total;
  logic [NB_W-1:0]   nb;

  always_comb begin
    is_enc   = (s1_func_r == FUNC_ENCODE);
    is_flush = (s1_func_r == FUNC_FLUSH);
    len_eff  = is_enc ? rd_entry.len : '0;
    mask     = ~({ACC_W{1'b1}} << len_eff);
    acc      = (ACC_W'(pend_r) << len_eff) | (ACC_W'(rd_entry.code) & mask);
    total    = TOT_W'(cnt_r) + TOT_W'(len_eff);
    aligned  = acc << (TOT_W'(ACC_W) - total);
    if (is_flush) begin
      nb = (cnt_r != '0) ? NB_W'(1) : '0;
    end else begin
      nb = NB_W'(total >> 3);
    end

    job.valid  = s1_valid_r && (nb != '0);
    job.nbytes = nb;
    job.bits   = aligned[ACC_W-1 -: JOB_W];

    advance     = !s1_valid_r || (nb == '0) || job_ready;
    stage_ready = advance;

    if (is_flush) begin
      pend_nxt = '0;
      cnt_nxt  = '0;
    end else begin
      pend_nxt = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[CNT_W-1:0]);
      cnt_nxt  = total[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_func_r  <= FUNC_LOAD;
      pend_r     <= '0;
      cnt_r      <= '0;
    end else begin
      if (advance) begin
        s1_valid_r <= in_take;
      end
      if (in_take) begin
        s1_func_r <= in_func;
      end
      if (s1_valid_r && advance) begin
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/hcbp_emit.sv @@
// Byte emitter: shifts out one byte of the current run per cycle, while the output is free, into the
// output register and marks the last one. Uses hcbp_pkg.
module hcbp_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  hcbp_pkg::job_t      job,
  output logic                job_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbp_pkg::out_word_t out_data
);
  import hcbp_pkg::*;

  logic [JOB_W-1:0] job_bits_r;
  logic [NB_W-1:0]  left_r;
  logic             out_valid_r;
  out_word_t        out_data_r;
  logic             out_free, load_out, take_job;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    load_out  = out_free && (left_r != '0);
    job_ready = (left_r == '0) || ((left_r == NB_W'(1)) && out_free);
    take_job  = job.valid && job_ready;
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take_job) begin
        left_r <= job.nbytes;
      end else if (load_out) begin
        left_r <= left_r - NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.out_byte    <= job_bits_r[JOB_W-1 -: 8];
      out_data_r.last_of_run <= (left_r == NB_W'(1));
    end
    if (take_job) begin
      job_bits_r <= job.bits;
    end else if (load_out) begin
      job_bits_r <= job_bits_r << 8;
    end
  end

endmodule

@@ hw/rtl/huffman_code_bit_packer.sv @@
// Huffman encoder back end: code table, bit accumulator and byte emitter.
// Depends on hcbp_pkg, hcbp_table, hcbp_pack and hcbp_emit.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_ready   | in_word_t
//   out_    | output    | out_valid / out_ready | out_word_t
//
// An item is registered at the table read, merged in the accumulator and
// handed to the emitter, which sends one byte per cycle while out_ready
// allows; an encode yields 0 to 4 bytes and a flush 0 or 1. Throughput
// is set by the emitter. The next item overlaps the last byte of the
// previous run. Reset clears all table lengths at once.
// A stalled out_ready backs up through the emitter into in_ready.
module huffman_code_bit_packer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbp_pkg::out_word_t out_data
);
  import hcbp_pkg::*;

  logic       in_take, job_ready, stage_ready;
  tbl_entry_t rd_entry;
  job_t       job;

  assign in_ready = stage_ready;
  assign in_take  = in_valid && stage_ready;

  hcbp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_take && (in_data.func == FUNC_LOAD)),
    .rd_en    (in_take),
    .sym      (in_data.symbol),
    .wr_code  (in_data.code_bits),
    .wr_len   (in_data.code_length),
    .rd_entry (rd_entry)
  );

  hcbp_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (in_take),
    .in_func     (in_data.func),
    .rd_entry    (rd_entry),
    .job_ready   (job_ready),
    .stage_ready (stage_ready),
    .job         (job)
  );

  hcbp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
